@@ src/ered_pkg.sv @@
// Shared types and constants for the ultrasonic echo ranger.
`default_nettype none

package ered_pkg;

    // Fixed field and register widths.
    localparam int LEN_W     = 16;
    localparam int GAP_W     = 17;
    localparam int DIV_W     = 16;
    localparam int PTICK_W   = 17;
    localparam int DIST_W    = 16;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CM_DIV    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INCH_DIV  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FOOT_DIV  = 3'd5;

    // Configuration reset values.
    localparam logic [LEN_W-1:0] RST_TRIG_LOW  = 16'd10;
    localparam logic [LEN_W-1:0] RST_TRIG_HIGH = 16'd20;
    localparam logic [GAP_W-1:0] RST_GAP       = 17'd120000;
    localparam logic [DIV_W-1:0] RST_CM_DIV    = 16'd116;
    localparam logic [DIV_W-1:0] RST_INCH_DIV  = 16'd296;
    localparam logic [DIV_W-1:0] RST_FOOT_DIV  = 16'd3552;

    // Unit selection codes.
    localparam logic [1:0] UNIT_CM   = 2'd0;
    localparam logic [1:0] UNIT_INCH = 2'd1;
    localparam logic [1:0] UNIT_FOOT = 2'd2;
    localparam logic [1:0] UNIT_NONE = 2'd3;

    localparam logic [DIST_W-1:0] DIST_MAX = 16'hFFFF;

    // Configuration register file contents.
    typedef struct packed {
        logic [LEN_W-1:0] trig_low;
        logic [LEN_W-1:0] trig_high;
        logic [GAP_W-1:0] gap;
        logic [DIV_W-1:0] cm_div;
        logic [DIV_W-1:0] inch_div;
        logic [DIV_W-1:0] foot_div;
    } cfg_t;

    // One classified input item.
    typedef struct packed {
        logic       is_start;
        logic       echo;
        logic [1:0] unit;
    } item_t;

    // Queue head as seen by the back end.
    typedef struct packed {
        logic  valid;
        item_t item;
    } qlink_t;

    // One result item.
    typedef struct packed {
        logic              trig;
        logic              busy;
        logic              done;
        logic [DIST_W-1:0] distance;
    } result_t;

endpackage

`default_nettype wire

@@ src/ered_front.sv @@
// Front end: accepts input items, classifies them and queues them for the back end.
`default_nettype none

module ered_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    output logic                item_ready,
    input  wire logic           action,
    input  wire logic           echo_level,
    input  wire logic [1:0]     unit_select,
    output ered_pkg::qlink_t    q_link,
    input  wire logic           q_ready
);
    import ered_pkg::*;

    item_t      slot_reg [2];
    logic       head_reg;
    logic       head_next;
    logic       tail_reg;
    logic       tail_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;
    item_t      in_item;

    // Classify the incoming item.
    always_comb
    begin
        in_item.is_start = action;
        in_item.echo     = echo_level;
        in_item.unit     = unit_select;
    end

    assign item_ready   = (count_reg != 2'd2);
    assign push         = item_valid && item_ready;
    assign q_link.valid = (count_reg != 2'd0);
    assign q_link.item  = slot_reg[head_reg];
    assign pop          = q_link.valid && q_ready;

    // Queue pointers and fill count.
    always_comb
    begin
        head_next  = pop ? ~head_reg : head_reg;
        tail_next  = push ? ~tail_reg : tail_reg;
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            tail_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail_reg] <= in_item;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue fill count out of range");

endmodule

`default_nettype wire

@@ src/ered_div.sv @@
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module ered_div #(
    parameter int N_W = 19,
    parameter int D_W = 19
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [N_W-1:0] dividend,
    input  wire logic [D_W-1:0] divisor,
    output logic                done,
    output logic [N_W-1:0]      quotient
);
    localparam int CNT_W = $clog2(N_W + 1);

    logic             active_reg;
    logic             active_next;
    logic             done_reg;
    logic             done_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   rem_next;
    logic [N_W-1:0]   quo_reg;
    logic [N_W-1:0]   quo_next;
    logic [D_W-1:0]   dvs_reg;
    logic [D_W-1:0]   dvs_next;
    logic [D_W:0]     trial;
    logic [D_W:0]     diff;
    logic             fits;

    // One shift-and-subtract step.
    always_comb
    begin
        trial = {rem_reg, quo_reg[N_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = (trial >= {1'b0, dvs_reg});
    end

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        dvs_next    = dvs_reg;
        if (start)
        begin
            active_next = 1'b1;
            cnt_next    = '0;
            rem_next    = '0;
            quo_next    = dividend;
            dvs_next    = divisor;
        end
        else if (active_reg)
        begin
            rem_next = fits ? diff[D_W-1:0] : trial[D_W-1:0];
            quo_next = {quo_reg[N_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(N_W - 1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !active_reg)
        else $error("divider started while busy");

endmodule

`default_nettype wire

@@ src/ered_back.sv @@
// Back end: ranging sequencer, final scaling divide and result register.
`default_nettype none

module ered_back #(
    parameter int SAMPLE_COUNT = 5,
    parameter int COUNT_WIDTH  = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire ered_pkg::cfg_t    cfg,
    input  wire ered_pkg::qlink_t  q_link,
    output logic                q_ready,
    output logic                result_valid,
    input  wire logic           result_ready,
    output ered_pkg::result_t   result
);
    import ered_pkg::*;

    localparam int SUM_W  = COUNT_WIDTH + $clog2(SAMPLE_COUNT + 1);
    localparam int DIVR_W = DIV_W + $clog2(SAMPLE_COUNT + 1);
    localparam int QX_W   = (SUM_W > DIST_W) ? SUM_W : DIST_W + 1;

    // Measurement phases.
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_LOW  = 3'd1;
    localparam logic [2:0] PH_HIGH = 3'd2;
    localparam logic [2:0] PH_RISE = 3'd3;
    localparam logic [2:0] PH_ECHO = 3'd4;
    localparam logic [2:0] PH_GAP  = 3'd5;

    // Back end control states.
    localparam logic BK_RUN = 1'b0;
    localparam logic BK_DIV = 1'b1;

    logic [2:0]             phase_reg;
    logic [2:0]             phase_next;
    logic [PTICK_W-1:0]     pticks_reg;
    logic [PTICK_W-1:0]     pticks_next;
    logic [COUNT_WIDTH-1:0] echo_reg;
    logic [COUNT_WIDTH-1:0] echo_next;
    logic [SUM_W-1:0]       sum_reg;
    logic [SUM_W-1:0]       sum_next;
    logic [2:0]             snum_reg;
    logic [2:0]             snum_next;
    logic [1:0]             unit_reg;
    logic [1:0]             unit_next;
    logic                   bstate_reg;
    logic                   bstate_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    result_t                out_res_reg;
    result_t                out_res_next;

    logic                   slot_free;
    logic                   pop;
    logic [PTICK_W-1:0]     len;
    logic [PTICK_W-1:0]     need;
    logic [PTICK_W-1:0]     pticks_inc;
    logic                   elapsed;
    logic                   last_sample;
    logic [DIV_W-1:0]       unit_div;
    logic                   unit_known;
    logic                   trig;
    logic                   finish;
    logic                   div_start;
    logic                   emit_now;
    logic [DIST_W-1:0]      early_dist;
    logic [DIVR_W-1:0]      scaled_div;
    logic                   div_done;
    logic [SUM_W-1:0]       div_quo;
    logic [QX_W-1:0]        quo_x;
    logic [DIST_W-1:0]      quo_sat;

    // An item is taken when no final divide is running and the result slot is free or being emptied.
    assign slot_free = !out_valid_reg || result_ready;
    assign q_ready   = (bstate_reg == BK_RUN) && slot_free;
    assign pop       = q_link.valid && q_ready;

    // Timed phase counter: a length of zero acts as one.
    always_comb
    begin
        unique case (phase_reg)
            PH_LOW:  len = PTICK_W'(cfg.trig_low);
            PH_HIGH: len = PTICK_W'(cfg.trig_high);
            default: len = cfg.gap;
        endcase
        need       = (len == '0) ? PTICK_W'(1) : len;
        pticks_inc = pticks_reg + 1'b1;
        elapsed    = (pticks_inc >= need);
    end

    assign last_sample = ({1'b0, snum_reg} >= 4'(SAMPLE_COUNT)) || (snum_reg == 3'd0);

    // Divisor of the held unit.
    always_comb
    begin
        unique case (unit_reg)
            UNIT_CM:   unit_div = cfg.cm_div;
            UNIT_INCH: unit_div = cfg.inch_div;
            UNIT_FOOT: unit_div = cfg.foot_div;
            default:   unit_div = '0;
        endcase
        unit_known = (unit_reg != UNIT_NONE);
    end

    // Sequencer step for the item at the queue head.
    always_comb
    begin
        phase_next  = phase_reg;
        pticks_next = pticks_reg;
        echo_next   = echo_reg;
        sum_next    = sum_reg;
        snum_next   = snum_reg;
        unit_next   = unit_reg;
        trig        = 1'b0;
        finish      = 1'b0;
        if (pop)
        begin
            if (q_link.item.is_start)
            begin
                if (phase_reg == PH_IDLE)
                begin
                    unit_next   = q_link.item.unit;
                    sum_next    = '0;
                    snum_next   = 3'd0;
                    echo_next   = '0;
                    pticks_next = '0;
                    phase_next  = PH_LOW;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_LOW:
                    begin
                        pticks_next = elapsed ? '0 : pticks_inc;
                        if (elapsed)
                        begin
                            phase_next = PH_HIGH;
                        end
                    end
                    PH_HIGH:
                    begin
                        trig        = 1'b1;
                        pticks_next = elapsed ? '0 : pticks_inc;
                        if (elapsed)
                        begin
                            phase_next = PH_RISE;
                        end
                    end
                    PH_RISE:
                    begin
                        if (q_link.item.echo)
                        begin
                            echo_next  = '0;
                            phase_next = PH_ECHO;
                        end
                    end
                    PH_ECHO:
                    begin
                        if (q_link.item.echo)
                        begin
                            if (echo_reg != '1)
                            begin
                                echo_next = echo_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            sum_next    = sum_reg + SUM_W'(echo_reg);
                            snum_next   = snum_reg + 3'd1;
                            pticks_next = '0;
                            phase_next  = PH_GAP;
                        end
                    end
                    PH_GAP:
                    begin
                        pticks_next = elapsed ? '0 : pticks_inc;
                        if (elapsed)
                        begin
                            if (last_sample)
                            begin
                                finish     = 1'b1;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                phase_next = PH_LOW;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Average and unit scaling as one divide: sum / (SAMPLE_COUNT * divisor).
    assign div_start  = pop && finish && unit_known && (unit_div != '0);
    assign emit_now   = pop && !div_start;
    assign early_dist = (finish && unit_known) ? DIST_MAX : '0;
    assign scaled_div = DIVR_W'(unit_div) * DIVR_W'(SAMPLE_COUNT);

    ered_div #(
        .N_W (SUM_W),
        .D_W (DIVR_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (scaled_div),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Saturate the quotient to the distance field.
    always_comb
    begin
        quo_x   = QX_W'(div_quo);
        quo_sat = (quo_x > QX_W'(DIST_MAX)) ? DIST_MAX : quo_x[DIST_W-1:0];
    end

    // Control state and result slot.
    always_comb
    begin
        bstate_next = bstate_reg;
        if (div_start)
        begin
            bstate_next = BK_DIV;
        end
        else if (div_done)
        begin
            bstate_next = BK_RUN;
        end

        out_valid_next = (out_valid_reg && !result_ready) || emit_now || div_done;
        out_res_next   = out_res_reg;
        if (emit_now)
        begin
            out_res_next.trig     = trig;
            out_res_next.busy     = (phase_next != PH_IDLE);
            out_res_next.done     = finish;
            out_res_next.distance = early_dist;
        end
        else if (div_done)
        begin
            out_res_next.trig     = 1'b0;
            out_res_next.busy     = 1'b0;
            out_res_next.done     = 1'b1;
            out_res_next.distance = quo_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            pticks_reg    <= '0;
            echo_reg      <= '0;
            sum_reg       <= '0;
            snum_reg      <= 3'd0;
            unit_reg      <= UNIT_CM;
            bstate_reg    <= BK_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pticks_reg    <= pticks_next;
            echo_reg      <= echo_next;
            sum_reg       <= sum_next;
            snum_reg      <= snum_next;
            unit_reg      <= unit_next;
            bstate_reg    <= bstate_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_res_reg;

    a_div_slot_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (bstate_reg == BK_DIV) |-> !out_valid_reg)
        else $error("result slot occupied during the final divide");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.done) |-> !out_res_reg.busy)
        else $error("completed measurement reported as busy");

    a_trig_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.trig) |-> (out_res_reg.busy && !out_res_reg.done))
        else $error("trigger pulse outside a running sequence");

    a_div_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (bstate_reg == BK_DIV) |-> (phase_reg == PH_IDLE))
        else $error("sequencer left idle during the final divide");

endmodule

`default_nettype wire

@@ src/ultrasonic_echo_ranger.sv @@
// Top level of the ultrasonic echo ranger: configuration registers, front end and back end.
//
// Channel   Handshake                    Payload
// item      item_valid / item_ready      action, echo_level, unit_select
// result    result_valid / result_ready  trigger_level, busy_res, done_res, distance
// config    cfg_write_en (no wait)       cfg_index, cfg_data
//
// A tick or start item passes the two-entry queue and is then handled by the back end.
// An item that completes a measurement in a known unit with a nonzero divisor starts the
// one-bit-per-cycle restoring divider; no item is taken until the quotient is registered.
// Reset is asynchronous and active low; it loads the register defaults and leaves the block idle.
// A stalled result holds in the output register while the queue accepts items until it is full.
`default_nettype none

module ultrasonic_echo_ranger #(
    parameter int SAMPLE_COUNT = 5,
    parameter int COUNT_WIDTH  = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_valid,
    output logic                                item_ready,
    input  wire logic                           action,
    input  wire logic                           echo_level,
    input  wire logic [1:0]                     unit_select,
    output logic                                result_valid,
    input  wire logic                           result_ready,
    output logic                                trigger_level,
    output logic                                busy_res,
    output logic                                done_res,
    output logic [ered_pkg::DIST_W-1:0]         distance,
    input  wire logic                           cfg_write_en,
    input  wire logic [ered_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ered_pkg::CFG_W-1:0]     cfg_data
);
    import ered_pkg::*;

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    qlink_t  q_link;
    logic    q_ready;
    result_t result;

    // Configuration register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_TRIG_LOW:  cfg_next.trig_low  = cfg_data[LEN_W-1:0];
                CFG_TRIG_HIGH: cfg_next.trig_high = cfg_data[LEN_W-1:0];
                CFG_GAP:       cfg_next.gap       = cfg_data[GAP_W-1:0];
                CFG_CM_DIV:    cfg_next.cm_div    = cfg_data[DIV_W-1:0];
                CFG_INCH_DIV:  cfg_next.inch_div  = cfg_data[DIV_W-1:0];
                CFG_FOOT_DIV:  cfg_next.foot_div  = cfg_data[DIV_W-1:0];
                default:       cfg_next           = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trig_low  <= RST_TRIG_LOW;
            cfg_reg.trig_high <= RST_TRIG_HIGH;
            cfg_reg.gap       <= RST_GAP;
            cfg_reg.cm_div    <= RST_CM_DIV;
            cfg_reg.inch_div  <= RST_INCH_DIV;
            cfg_reg.foot_div  <= RST_FOOT_DIV;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ered_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .action      (action),
        .echo_level  (echo_level),
        .unit_select (unit_select),
        .q_link      (q_link),
        .q_ready     (q_ready)
    );

    ered_back #(
        .SAMPLE_COUNT (SAMPLE_COUNT),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_link       (q_link),
        .q_ready      (q_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Result fields to ports.
    assign trigger_level = result.trig;
    assign busy_res      = result.busy;
    assign done_res      = result.done;
    assign distance      = result.distance;

endmodule

`default_nettype wire
